// ===== rtl/aec_pkg.sv =====
package aec_pkg;

  localparam int COORD_BITS       = 12;
  localparam int LENGTH_FRAC_BITS = 16;
  localparam int FADE_TABLE_DEPTH = 256;

  localparam int PIX_W  = 12;
  localparam int SEMI_W = 15;
  localparam int SQ_W   = 2 * SEMI_W;
  localparam int AD_W   = PIX_W + 4;
  localparam int D2_W   = 2 * AD_W;
  localparam int F      = LENGTH_FRAC_BITS;
  localparam int RB     = F + 9;
  localparam int R_W    = RB + 1;
  localparam int P_W    = $clog2(SQ_W);
  localparam int SH_W   = $clog2(SQ_W + RB - F + 1);
  localparam int REM_W  = SQ_W + 2;
  localparam int CNT_W  = $clog2(R_W);
  localparam int Q_W    = F + 3;
  localparam int L_W    = F + 4;
  localparam int PROD_W = D2_W + R_W;
  localparam int CHKQ_W = Q_W + 1 + SQ_W;
  localparam int N_W    = F;
  localparam int IDX_W  = $clog2(FADE_TABLE_DEPTH);
  localparam int T_W    = N_W + IDX_W;
  localparam int K_W    = T_W;
  localparam int M_W    = IDX_W + 6;
  localparam int A_W    = T_W + M_W;
  localparam int CHKI_W = IDX_W + 1 + N_W;
  localparam int LAT    = 15;

  localparam longint unsigned L_ONE = 64'd1 << F;
  localparam longint unsigned L_CAP = 64'd4 << F;
  localparam longint unsigned T_LO  = ((64'd9409 << F) + 64'd5000) / 64'd10000;
  localparam longint unsigned T_HI  = ((64'd10609 << F) + 64'd5000) / 64'd10000;
  localparam longint unsigned DN_OUT = L_ONE - T_LO;
  localparam longint unsigned DN_IN  = T_HI - L_ONE;
  localparam longint unsigned M_OUT  = (64'd1 << K_W) / DN_OUT;
  localparam longint unsigned M_IN   = (64'd1 << K_W) / DN_IN;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned FADE_DEN    = FADE_TABLE_DEPTH - 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 8'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic       pixel_white;
    logic [7:0] pixel_alpha;
  } pixel_out_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_NORM   = 4'b0100,
    ST_DIV    = 4'b1000
  } seq_state_t;

  typedef logic [7:0] fade_lut_t [FADE_TABLE_DEPTH];

  function automatic fade_lut_t build_fade_lut();
    fade_lut_t lut;
    longint unsigned x, x2, t, s, a;
    for (int i = 0; i < FADE_TABLE_DEPTH; i++) begin
      x  = (HALF_PI_Q30 * longint'(i)) / FADE_DEN;
      x2 = (x * x) >> 30;
      s  = x;
      t  = ((x * x2) >> 30) / 6;
      s  = s - t;
      t  = ((t * x2) >> 30) / 20;
      s  = s + t;
      t  = ((t * x2) >> 30) / 42;
      s  = s - t;
      t  = ((t * x2) >> 30) / 72;
      s  = s + t;
      a  = (64'd255 * s) >> 30;
      if (a > 64'd255) a = 64'd255;
      lut[i] = a[7:0];
    end
    return lut;
  endfunction

  localparam fade_lut_t FADE_LUT = build_fade_lut();

endpackage

// ===== rtl/antialiased_ellipse_coverage.sv =====
// Throughput: one pixel per cycle while busy is low; the pipeline never stalls.
// After reset or any register write, busy stays high while a serial divider
// forms the four axis reciprocals, one after another.
// Reset is synchronous and active low; the result strobe cannot be held off.
module antialiased_ellipse_coverage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  aec_pkg::pixel_in_t           in_pixel,
  output logic                         out_valid,
  output aec_pkg::pixel_out_t          out_pixel,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [aec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aec_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aec_pkg::*;

  logic [SEMI_W-1:0] semi_x_r, semi_y_r, border_r;
  logic              mode_r;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      semi_x_r <= SEMI_W'(1024);
      semi_y_r <= SEMI_W'(1024);
      border_r <= SEMI_W'(16);
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEMI_X: semi_x_r <= cfg_data[SEMI_W-1:0];
        REG_SEMI_Y: semi_y_r <= cfg_data[SEMI_W-1:0];
        REG_BORDER: border_r <= cfg_data[SEMI_W-1:0];
        REG_MODE:   mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Reciprocal setup sequencer.
  seq_state_t        st_r, st_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [SQ_W-1:0]   sq_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [R_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SQ_W-1:0]   s_r   [4];
  logic [SQ_W+2:0]   s5_r  [4];
  logic [R_W-1:0]    rcp_r [4];
  logic [SH_W-1:0]   sh_r  [4];

  logic [SEMI_W-1:0] sx_eff, sy_eff, smin, bw_sat, semi_cur;
  logic [P_W-1:0]    msb_pos;
  logic [REM_W-1:0]  rem_sub;
  logic              qbit;

  always_comb begin
    sx_eff = (semi_x_r == '0) ? SEMI_W'(1) : semi_x_r;
    sy_eff = (semi_y_r == '0) ? SEMI_W'(1) : semi_y_r;
    smin   = (sx_eff < sy_eff) ? sx_eff : sy_eff;
    bw_sat = (border_r > smin - SEMI_W'(1)) ? smin - SEMI_W'(1) : border_r;
    case (axis_r)
      2'd0:    semi_cur = sx_eff;
      2'd1:    semi_cur = sy_eff;
      2'd2:    semi_cur = sx_eff - bw_sat;
      default: semi_cur = sy_eff - bw_sat;
    endcase
    msb_pos = '0;
    for (int i = 0; i < SQ_W; i++) begin
      if (sq_r[i]) msb_pos = P_W'(i);
    end
    qbit    = rem_r >= REM_W'(sq_r);
    rem_sub = qbit ? rem_r - REM_W'(sq_r) : rem_r;
  end

  always_comb begin
    st_nxt   = st_r;
    axis_nxt = axis_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    unique case (st_r)
      ST_IDLE: ;
      ST_SQUARE: st_nxt = ST_NORM;
      ST_NORM: begin
        rem_nxt = REM_W'(1) << msb_pos;
        quo_nxt = '0;
        cnt_nxt = CNT_W'(R_W - 1);
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        quo_nxt = {quo_r[R_W-2:0], qbit};
        rem_nxt = {rem_sub[REM_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          if (axis_r == 2'd3) begin
            st_nxt = ST_IDLE;
          end else begin
            axis_nxt = axis_r + 2'd1;
            st_nxt   = ST_SQUARE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (cfg_we) begin
      st_nxt   = ST_SQUARE;
      axis_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_SQUARE;
      axis_r <= 2'd0;
    end else begin
      st_r   <= st_nxt;
      axis_r <= axis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (st_r == ST_SQUARE) sq_r <= SQ_W'(semi_cur * semi_cur);
    if (st_r == ST_NORM) begin
      s_r[axis_r]  <= sq_r;
      s5_r[axis_r] <= (SQ_W+3)'({sq_r, 2'b00}) + (SQ_W+3)'(sq_r);
      sh_r[axis_r] <= SH_W'(msb_pos) + SH_W'(RB - F);
    end
    if (st_r == ST_DIV && cnt_r == '0) rcp_r[axis_r] <= quo_nxt;
  end

  assign busy = (st_r != ST_IDLE);

  // Pixel pipeline.
  logic [LAT:1] vld_r;
  logic         accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-1:1], accept};
  end

  localparam logic [PIX_W-1:0] CMASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

  logic [PIX_W-1:0]  px1_r, py1_r;
  logic [AD_W-1:0]   adx2_r, ady2_r;
  logic [D2_W-1:0]   d2x3_r, d2y3_r;
  logic [D2_W-1:0]   d2x4_r, d2y4_r, d2x5_r, d2y5_r, d2x6_r, d2y6_r;
  logic [PROD_W-1:0] prod4_r [4];
  logic [3:0]        big4_r, big5_r, big6_r;
  logic [Q_W-1:0]    qa5_r [4];
  logic [Q_W-1:0]    qa6_r [4];
  logic [CHKQ_W-1:0] chk6_r [4];
  logic [Q_W-1:0]    q7_r [4];
  logic [L_W-1:0]    lo8_r, li8_r;
  logic              white9_r, opq9_r, inr9_r;
  logic [N_W-1:0]    n9_r;
  logic              white10_r, opq10_r, inr10_r;
  logic [T_W-1:0]    t10_r, t11_r, t12_r, t13_r;
  logic              white11_r, opq11_r, inr11_r;
  logic [A_W-1:0]    a11_r;
  logic              white12_r, opq12_r, inr12_r;
  logic [IDX_W-1:0]  ip12_r, ip13_r;
  logic              white13_r, opq13_r;
  logic [CHKI_W-1:0] chk13_r;
  logic              white14_r, opq14_r;
  logic [IDX_W-1:0]  idx14_r;
  pixel_out_t        out_r;

  logic [AD_W:0]     dx, dy;
  logic [D2_W-1:0]   d2sel [4];
  logic [Q_W-1:0]    qfix [4];
  logic              w9, o9, i9;
  logic [N_W-1:0]    n9;

  always_comb begin
    dx = {px1_r, 4'b0000} - (AD_W+1)'(sx_eff);
    dy = {py1_r, 4'b0000} - (AD_W+1)'(sy_eff);
    d2sel[0] = d2x3_r;
    d2sel[1] = d2y3_r;
    d2sel[2] = d2x3_r;
    d2sel[3] = d2y3_r;
    for (int k = 0; k < 4; k++) begin
      if (big6_r[k]) begin
        qfix[k] = Q_W'(L_CAP);
      end else begin
        if (chk6_r[k] <= CHKQ_W'({(k[0] ? d2y6_r : d2x6_r), {F{1'b0}}}))
          qfix[k] = qa6_r[k] + Q_W'(1);
        else
          qfix[k] = qa6_r[k];
        if (qfix[k] > Q_W'(L_CAP)) qfix[k] = Q_W'(L_CAP);
      end
    end
    w9 = 1'b0;
    o9 = 1'b0;
    i9 = 1'b0;
    n9 = N_W'(L_ONE - 64'(lo8_r));
    if (!mode_r) begin
      if (lo8_r <= L_W'(T_LO)) begin
        w9 = 1'b1; o9 = 1'b1;
      end else if (lo8_r <= L_W'(L_ONE)) begin
        w9 = 1'b1;
      end
    end else begin
      if (lo8_r <= L_W'(T_LO) && li8_r >= L_W'(T_HI)) begin
        w9 = 1'b1; o9 = 1'b1;
      end else if (lo8_r <= L_W'(L_ONE) && li8_r >= L_W'(T_HI)) begin
        w9 = 1'b1;
      end else if (lo8_r <= L_W'(T_LO) && li8_r >= L_W'(L_ONE)) begin
        w9 = 1'b1; i9 = 1'b1;
        n9 = N_W'(64'(li8_r) - L_ONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    px1_r  <= in_pixel.pixel_x & CMASK;
    py1_r  <= in_pixel.pixel_y & CMASK;
    adx2_r <= dx[AD_W] ? AD_W'(-dx) : dx[AD_W-1:0];
    ady2_r <= dy[AD_W] ? AD_W'(-dy) : dy[AD_W-1:0];
    d2x3_r <= adx2_r * adx2_r;
    d2y3_r <= ady2_r * ady2_r;
    d2x4_r <= d2x3_r;
    d2y4_r <= d2y3_r;
    d2x5_r <= d2x4_r;
    d2y5_r <= d2y4_r;
    d2x6_r <= d2x5_r;
    d2y6_r <= d2y5_r;
    big5_r <= big4_r;
    big6_r <= big5_r;
    for (int k = 0; k < 4; k++) begin
      prod4_r[k] <= PROD_W'(d2sel[k] * rcp_r[k]);
      big4_r[k]  <= (SQ_W+3)'(d2sel[k]) >= s5_r[k];
      qa5_r[k]   <= Q_W'(prod4_r[k] >> sh_r[k]);
      qa6_r[k]   <= qa5_r[k];
      chk6_r[k]  <= CHKQ_W'(((Q_W+1)'(qa5_r[k]) + (Q_W+1)'(1)) * s_r[k]);
      q7_r[k]    <= qfix[k];
    end
    lo8_r     <= L_W'(q7_r[0]) + L_W'(q7_r[1]);
    li8_r     <= L_W'(q7_r[2]) + L_W'(q7_r[3]);
    white9_r  <= w9;
    opq9_r    <= o9;
    inr9_r    <= i9;
    n9_r      <= n9;
    white10_r <= white9_r;
    opq10_r   <= opq9_r;
    inr10_r   <= inr9_r;
    t10_r     <= T_W'(n9_r * IDX_W'(FADE_TABLE_DEPTH - 1));
    white11_r <= white10_r;
    opq11_r   <= opq10_r;
    inr11_r   <= inr10_r;
    t11_r     <= t10_r;
    a11_r     <= A_W'(t10_r * (inr10_r ? M_W'(M_IN) : M_W'(M_OUT)));
    white12_r <= white11_r;
    opq12_r   <= opq11_r;
    inr12_r   <= inr11_r;
    t12_r     <= t11_r;
    ip12_r    <= IDX_W'(a11_r >> K_W);
    white13_r <= white12_r;
    opq13_r   <= opq12_r;
    t13_r     <= t12_r;
    ip13_r    <= ip12_r;
    chk13_r   <= CHKI_W'(((IDX_W+1)'(ip12_r) + (IDX_W+1)'(1))
                 * (inr12_r ? N_W'(DN_IN) : N_W'(DN_OUT)));
    white14_r <= white13_r;
    opq14_r   <= opq13_r;
    idx14_r   <= (chk13_r <= CHKI_W'(t13_r)) ? ip13_r + IDX_W'(1) : ip13_r;
    out_r.pixel_white <= white14_r;
    out_r.pixel_alpha <= !white14_r ? 8'd0 : (opq14_r ? 8'd255 : FADE_LUT[idx14_r]);
  end

  assign out_valid = vld_r[LAT];
  assign out_pixel = out_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("result strobe missing after accepted pixel");

  a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel.pixel_white |-> out_pixel.pixel_alpha == 8'd0)
    else $error("transparent pixel with nonzero alpha");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("register write did not start reciprocal setup");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !vld_r[1])
    else $error("pixel entered pipeline during setup");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import aec_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  pixel_in_t  in_pixel;
  logic       out_valid;
  pixel_out_t out_pixel;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  antialiased_ellipse_coverage u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_pixel(out_pixel), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int SENT_TARGET = 1650;

  pixel_out_t coverage_q[$];
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned reg_writes;
  bit          steady_stream;

  logic [14:0] semi_x_r, semi_y_r, border_r;
  logic        ring_mode_r;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12ms;
    $display("[antialiased_ellipse_coverage] ERROR");
    $finish;
  end

  function automatic longint unsigned axis_term(longint d, longint unsigned s);
    longint unsigned ad, q;
    ad = (d < 0) ? longint'(-d) : longint'(d);
    q  = ((ad * ad) << F) / (s * s);
    return (q > L_CAP) ? L_CAP : q;
  endfunction

  function automatic logic [7:0] sine_fade(longint unsigned idx);
    longint unsigned x, x2, t, s, a;
    if (idx > FADE_TABLE_DEPTH - 1) idx = FADE_TABLE_DEPTH - 1;
    x  = (HALF_PI_Q30 * idx) / (FADE_TABLE_DEPTH - 1);
    x2 = (x * x) >> 30;
    s  = x;
    t  = ((x * x2) >> 30) / 6;
    s  = s - t;
    t  = ((t * x2) >> 30) / 20;
    s  = s + t;
    t  = ((t * x2) >> 30) / 42;
    s  = s - t;
    t  = ((t * x2) >> 30) / 72;
    s  = s + t;
    a  = (64'd255 * s) >> 30;
    if (a > 255) a = 255;
    return a[7:0];
  endfunction

  function automatic pixel_out_t predict_coverage(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    longint unsigned sx, sy, smin, bw, lo, li;
    longint dx, dy;
    pixel_out_t r;
    sx = (semi_x_r == 0) ? 1 : semi_x_r;
    sy = (semi_y_r == 0) ? 1 : semi_y_r;
    dx = longint'({px, 4'b0}) - longint'(sx);
    dy = longint'({py, 4'b0}) - longint'(sy);
    lo = axis_term(dx, sx) + axis_term(dy, sy);
    r  = '0;
    if (!ring_mode_r) begin
      if (lo <= T_LO) begin
        r.pixel_white = 1'b1;
        r.pixel_alpha = 8'd255;
      end else if (lo <= L_ONE) begin
        r.pixel_white = 1'b1;
        r.pixel_alpha = sine_fade(((L_ONE - lo) * (FADE_TABLE_DEPTH - 1)) / (L_ONE - T_LO));
      end
    end else begin
      smin = (sx < sy) ? sx : sy;
      bw   = border_r;
      if (bw > smin - 1) bw = smin - 1;
      li = axis_term(dx, sx - bw) + axis_term(dy, sy - bw);
      if (lo <= T_LO && li >= T_HI) begin
        r.pixel_white = 1'b1;
        r.pixel_alpha = 8'd255;
      end else if (lo <= L_ONE && li >= T_HI) begin
        r.pixel_white = 1'b1;
        r.pixel_alpha = sine_fade(((L_ONE - lo) * (FADE_TABLE_DEPTH - 1)) / (L_ONE - T_LO));
      end else if (lo <= T_LO && li >= L_ONE) begin
        r.pixel_white = 1'b1;
        r.pixel_alpha = sine_fade(((li - L_ONE) * (FADE_TABLE_DEPTH - 1)) / (T_HI - L_ONE));
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (coverage_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual white=%0b alpha=%0d",
                 $realtime, out_pixel.pixel_white, out_pixel.pixel_alpha);
      end else begin
        pixel_out_t e;
        e = coverage_q.pop_front();
        if (e.pixel_white !== out_pixel.pixel_white) begin
          mismatches++;
          $display("%0t: pixel_white expected %0b actual %0b", $realtime,
                   e.pixel_white, out_pixel.pixel_white);
        end
        if (e.pixel_alpha !== out_pixel.pixel_alpha) begin
          mismatches++;
          $display("%0t: pixel_alpha expected %0d actual %0d", $realtime,
                   e.pixel_alpha, out_pixel.pixel_alpha);
        end
      end
    end
  end

  task automatic send_pixel(input int px, input int py);
    logic [PIX_W-1:0] bx, by;
    bx = PIX_W'(px);
    by = PIX_W'(py);
    if (!steady_stream && $urandom_range(99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start    <= 1'b1;
    in_pixel <= '{pixel_x: bx, pixel_y: by};
    do @(posedge clk); while (busy);
    coverage_q.push_back(predict_coverage(bx, by));
    pixels_sent++;
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (coverage_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] bv;
    bv = CFG_DATA_W'(val);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bv;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_SEMI_X: semi_x_r = bv;
      REG_SEMI_Y: semi_y_r = bv;
      REG_BORDER: border_r = bv;
      REG_MODE:   ring_mode_r = bv[0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input int sx, input int sy, input int bw, input int ring);
    write_reg(REG_SEMI_X, sx);
    write_reg(REG_SEMI_Y, sy);
    write_reg(REG_BORDER, bw);
    write_reg(REG_MODE, ring);
  endtask

  task automatic send_near_edge();
    int sx, sy, ex, ey;
    sx = (semi_x_r == 0) ? 1 : int'(semi_x_r);
    sy = (semi_y_r == 0) ? 1 : int'(semi_y_r);
    ex = ((sx * 2) >> 4) + 2;
    ey = ((sy * 2) >> 4) + 2;
    if (ex > 4095) ex = 4095;
    if (ey > 4095) ey = 4095;
    if ($urandom_range(99) < 15) send_pixel($urandom_range(4095), $urandom_range(4095));
    else send_pixel($urandom_range(ex), $urandom_range(ey));
  endtask

  task automatic test_reset_defaults();
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(64, 64);
    send_pixel(64, 0);
    send_pixel(0, 64);
    send_pixel(64, 2);
    send_pixel(4095, 0);
  endtask

  task automatic test_fill_edges();
    set_shape(160, 160, 16, 0);
    for (int i = 0; i <= 20; i++) send_pixel(i, 10);
  endtask

  task automatic test_border_ring();
    set_shape(320, 240, 48, 1);
    for (int i = 0; i <= 20; i++) send_pixel(i, 15);
    write_reg(REG_BORDER, 32'h7fff);
    for (int i = 0; i <= 20; i++) send_pixel(i, 15);
  endtask

  task automatic test_degenerate_axes();
    set_shape(0, 0, 0, 1);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    write_reg(8'd7, 32'h1234);
    write_reg(8'hff, 32'h7fff);
    send_pixel(0, 0);
    set_shape(32'h7fff, 32'h7fff, 32'h7fff, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    send_pixel(2048, 2048);
    write_reg(REG_MODE, 1);
    send_pixel(4095, 2048);
    send_pixel(2048, 0);
  endtask

  task automatic test_random_shapes();
    int phase;
    phase = 0;
    while (pixels_sent < SENT_TARGET) begin
      int sx, sy;
      sx = ($urandom_range(19) == 0) ? $urandom_range(32767) : $urandom_range(1200, 16);
      sy = ($urandom_range(19) == 0) ? $urandom_range(32767) : $urandom_range(1200, 16);
      set_shape(sx, sy, $urandom_range(sx < sy ? sx : sy), $urandom_range(1));
      steady_stream = (phase == 3);
      for (int k = 0; k < 60; k++) begin
        send_near_edge();
        if (phase == 5 && k == 30) drain_pipeline();
      end
      phase++;
    end
    steady_stream = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    pixels_sent = 0;
    results_seen = 0;
    reg_writes = 0;
    steady_stream = 1'b0;
    semi_x_r = 15'd1024;
    semi_y_r = 15'd1024;
    border_r = 15'd16;
    ring_mode_r = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_fill_edges();
    test_border_ring();
    test_degenerate_axes();
    test_random_shapes();
    drain_pipeline();
    if (coverage_q.size() != 0) mismatches++;
    $display("Sent %0d pixels over fill and ring shapes, %0d register writes,", pixels_sent,
             reg_writes);
    $display("checked %0d coverage results including degenerate and oversized axes.",
             results_seen);
    if (mismatches == 0) begin
      $display("[antialiased_ellipse_coverage] OK");
    end else begin
      $display("[antialiased_ellipse_coverage] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aec_pkg.sv
rtl/antialiased_ellipse_coverage.sv
bench/tb.sv
